>>> rtl/hrp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser: shared types and constants
// Character class bits, the queued byte item, the result record and the
// result kind codes used by the front, back and result queue.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // Result field widths
  localparam int KIND_W = 3;
  localparam int SPAN_W = 16;
  localparam int VER_W  = 4;

  // Queue depths (powers of two)
  localparam int BYTE_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH  = 4;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_METHOD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PATH    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VERSION = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NAME    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_VALUE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd7;

  // Character classes of one byte
  typedef struct packed {
    logic tchar;
    logic pchar;
    logic hex;
    logic digit;
    logic vchar;
    logic sp;
    logic tab;
    logic cr;
    logic lf;
    logic slash;
    logic qmark;
    logic pct;
    logic colon;
    logic up_h;
    logic up_t;
    logic up_p;
    logic dot;
  } char_class_t;

  // Classified byte waiting for the back end
  typedef struct packed {
    char_class_t      cls;
    logic [VER_W-1:0] low_nibble;
    logic             eom;
  } byte_item_t;

  // One result record
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SPAN_W-1:0] offset;
    logic [SPAN_W-1:0] length;
    logic [VER_W-1:0]  major;
    logic [VER_W-1:0]  minor;
    logic              last;
  } result_t;

  // Result writes from the back end in one cycle
  typedef struct packed {
    logic first;
    logic second;
  } res_push_t;

endpackage

`default_nettype wire

>>> rtl/http_request_head_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser core
// Checks an HTTP/1.1 request head byte by byte and reports its spans.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on data_byte/end_of_message and are taken when push is high
//   and full is low. Results (method, path, query, version, field name,
//   field value, done, error) leave as a queue: the oldest waits on the span
//   ports while empty is low and is taken when pop is high.
//   A byte gives zero, one or two results; run_last marks the final one.
//   A taken byte is registered in the byte queue, and its results are
//   registered in the result queue before they reach the span ports.
//   Throughput: one byte per cycle while the result queue has room, set by the
//   combinational grammar step; a byte giving two results writes both at once.
//   Reset (rst, synchronous) empties both queues and returns the grammar
//   to the first method character at position zero.
//   When the receiver stops popping, the result queue fills, the back end
//   holds (it steps only with room for two results), the byte queue fills
//   and full rises. No item is lost or repeated across stalls.
//   end_of_message always returns the parser to its start state.
// ----------------------------------------------------------------------------
module http_request_head_parser_core #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [7:0]                    data_byte,
  input  wire logic                          end_of_message,
  input  wire logic                          push,
  output logic                               full,
  output logic [hrp_pkg::KIND_W-1:0]         span_kind,
  output logic [hrp_pkg::SPAN_W-1:0]         span_offset,
  output logic [hrp_pkg::SPAN_W-1:0]         span_length,
  output logic [hrp_pkg::VER_W-1:0]          major_version,
  output logic [hrp_pkg::VER_W-1:0]          minor_version,
  output logic                               run_last,
  output logic                               empty,
  input  wire logic                          pop
);

  hrp_pkg::byte_item_t item;
  logic                item_valid;
  logic                item_take;
  logic                room;
  hrp_pkg::res_push_t  res_push;
  hrp_pkg::result_t    res0;
  hrp_pkg::result_t    res1;
  hrp_pkg::result_t    head;

  // Classify and queue incoming bytes
  hrp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .push           (push),
    .full           (full),
    .item           (item),
    .item_valid     (item_valid),
    .item_take      (item_take)
  );

  // Run the grammar
  hrp_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take),
    .room       (room),
    .res_push   (res_push),
    .res0       (res0),
    .res1       (res1)
  );

  // Hold results for the receiver
  hrp_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res0     (res0),
    .res1     (res1),
    .room     (room),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign span_kind     = head.kind;
  assign span_offset   = head.offset;
  assign span_length   = head.length;
  assign major_version = head.major;
  assign minor_version = head.minor;
  assign run_last      = head.last;

endmodule

`default_nettype wire

>>> rtl/hrp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser: front end
// Accepts raw bytes, sorts each into its character classes and holds the
// classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module hrp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_message,
  input  wire logic              push,
  output logic                   full,
  output hrp_pkg::byte_item_t    item,
  output logic                   item_valid,
  input  wire logic              item_take
);

  localparam int DEPTH = hrp_pkg::BYTE_Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  hrp_pkg::byte_item_t mem [DEPTH];
  logic [AW-1:0]       wptr;
  logic [AW-1:0]       rptr;
  logic [AW:0]         count;
  logic                wr;
  logic                rd;
  hrp_pkg::byte_item_t new_item;

  // Sort one byte into the grammar's character classes
  function automatic hrp_pkg::char_class_t classify(input logic [7:0] c);
    hrp_pkg::char_class_t k;
    logic alpha;
    logic dig;
    alpha   = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    dig     = (c >= 8'h30 && c <= 8'h39);
    k.digit = dig;
    k.hex   = dig || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    k.vchar = (c >= 8'h21 && c <= 8'h7E) || (c >= 8'h80);
    k.tchar = alpha || dig ||
              c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 || c == 8'h26 ||
              c == 8'h27 || c == 8'h2A || c == 8'h2B || c == 8'h2D || c == 8'h2E ||
              c == 8'h5E || c == 8'h5F || c == 8'h60 || c == 8'h7C || c == 8'h7E;
    k.pchar = alpha || dig ||
              c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E || c == 8'h21 ||
              c == 8'h24 || c == 8'h26 || c == 8'h27 || c == 8'h28 || c == 8'h29 ||
              c == 8'h2A || c == 8'h2B || c == 8'h2C || c == 8'h3B || c == 8'h3D ||
              c == 8'h3A || c == 8'h40;
    k.sp    = (c == 8'h20);
    k.tab   = (c == 8'h09);
    k.cr    = (c == 8'h0D);
    k.lf    = (c == 8'h0A);
    k.slash = (c == 8'h2F);
    k.qmark = (c == 8'h3F);
    k.pct   = (c == 8'h25);
    k.colon = (c == 8'h3A);
    k.up_h  = (c == 8'h48);
    k.up_t  = (c == 8'h54);
    k.up_p  = (c == 8'h50);
    k.dot   = (c == 8'h2E);
    return k;
  endfunction

  // Build the queued item
  always_comb begin
    new_item.cls        = classify(data_byte);
    new_item.low_nibble = data_byte[3:0];
    new_item.eom        = end_of_message;
  end

  assign full       = (count == (AW + 1)'(DEPTH));
  assign item_valid = (count != '0);
  assign item       = mem[rptr];
  assign wr         = push && !full;
  assign rd         = item_valid && item_take;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + AW'(1);
      end
      if (rd) begin
        rptr <= rptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + (AW + 1)'(1);
      end else if (rd && !wr) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= new_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hrp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser: back end
// Runs the request-line and header grammar, one classified item a cycle while
// room is high; tracks positions and emits up to two result records per item.
// ----------------------------------------------------------------------------
module hrp_back #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hrp_pkg::byte_item_t item,
  input  wire logic                item_valid,
  output logic                     item_take,
  input  wire logic                room,
  output hrp_pkg::res_push_t       res_push,
  output hrp_pkg::result_t         res0,
  output hrp_pkg::result_t         res1
);

  localparam int PW = POSITION_WIDTH;
  localparam int SW = hrp_pkg::SPAN_W;
  localparam int VW = hrp_pkg::VER_W;

  typedef enum logic [4:0] {
    PH_M_FIRST   = 5'd0,
    PH_M_REST    = 5'd1,
    PH_T_SLASH   = 5'd2,
    PH_PATH      = 5'd3,
    PH_PATH_HEX  = 5'd4,
    PH_QUERY     = 5'd5,
    PH_QUERY_HEX = 5'd6,
    PH_V_H       = 5'd7,
    PH_V_T1      = 5'd8,
    PH_V_T2      = 5'd9,
    PH_V_P       = 5'd10,
    PH_V_SL      = 5'd11,
    PH_V_MAJ     = 5'd12,
    PH_V_DOT     = 5'd13,
    PH_V_MIN     = 5'd14,
    PH_CR        = 5'd15,
    PH_LF        = 5'd16,
    PH_F_FIRST   = 5'd17,
    PH_F_NAME    = 5'd18,
    PH_OWS       = 5'd19,
    PH_VALUE     = 5'd20,
    PH_END_LF    = 5'd21,
    PH_DONE      = 5'd22,
    PH_FAILED    = 5'd23
  } phase_t;

  phase_t                    phase;
  phase_t                    phase_next;
  logic [PW-1:0]             pos;
  logic [PW-1:0]             pos_next;
  logic [PW-1:0]             span_start;
  logic [PW-1:0]             span_start_next;
  logic [1:0]                hex_pending;
  logic [1:0]                hex_pending_next;
  logic [VW-1:0]             held_major;
  logic [VW-1:0]             held_major_next;

  logic                      go;
  logic [PW-1:0]             len;
  logic                      fail;
  logic                      err;
  logic                      span_ok;
  logic [hrp_pkg::KIND_W-1:0] span_kind;
  logic [PW-1:0]             span_off;
  logic [PW-1:0]             span_len;
  logic [VW-1:0]             span_minor;
  logic                      in_query;
  hrp_pkg::char_class_t      c;

  assign go        = item_valid && room;
  assign item_take = go;
  assign c         = item.cls;
  assign len       = pos - span_start;
  assign in_query  = (phase == PH_QUERY) || (phase == PH_QUERY_HEX);

  // Grammar step for the item at the head of the queue
  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    span_start_next  = span_start;
    hex_pending_next = hex_pending;
    held_major_next  = held_major;
    fail             = 1'b0;
    err              = 1'b0;
    span_ok          = 1'b0;
    span_kind        = hrp_pkg::KIND_METHOD;
    span_off         = span_start;
    span_len         = len;
    span_minor       = '0;

    if (phase == PH_DONE || phase == PH_FAILED) begin
      // idle until the end of the message
    end else begin
      if (pos == '1) begin
        fail = 1'b1;
      end else begin
        pos_next = pos + PW'(1);
        case (phase)
          PH_M_FIRST: begin
            if (c.tchar) begin
              span_start_next = pos;
              phase_next      = PH_M_REST;
            end else begin
              fail = 1'b1;
            end
          end
          PH_M_REST: begin
            if (c.tchar) begin
              phase_next = PH_M_REST;
            end else if (c.sp) begin
              span_ok    = 1'b1;
              span_kind  = hrp_pkg::KIND_METHOD;
              phase_next = PH_T_SLASH;
            end else begin
              fail = 1'b1;
            end
          end
          PH_T_SLASH: begin
            if (c.slash) begin
              span_start_next = pos;
              phase_next      = PH_PATH;
            end else begin
              fail = 1'b1;
            end
          end
          PH_PATH, PH_QUERY: begin
            if (c.pchar || c.slash || (c.qmark && in_query)) begin
              phase_next = phase;
            end else if (c.pct) begin
              hex_pending_next = 2'd2;
              phase_next       = in_query ? PH_QUERY_HEX : PH_PATH_HEX;
            end else if (c.qmark) begin
              span_ok         = 1'b1;
              span_kind       = hrp_pkg::KIND_PATH;
              span_start_next = pos;
              phase_next      = PH_QUERY;
            end else if (c.sp) begin
              span_ok    = 1'b1;
              span_kind  = in_query ? hrp_pkg::KIND_QUERY : hrp_pkg::KIND_PATH;
              phase_next = PH_V_H;
            end else begin
              fail = 1'b1;
            end
          end
          PH_PATH_HEX, PH_QUERY_HEX: begin
            if (!c.hex) begin
              fail = 1'b1;
            end else begin
              hex_pending_next = hex_pending - 2'd1;
              if (hex_pending == 2'd1) begin
                phase_next = in_query ? PH_QUERY : PH_PATH;
              end
            end
          end
          PH_V_H: begin
            if (c.up_h) begin
              span_start_next = pos;
              phase_next      = PH_V_T1;
            end else begin
              fail = 1'b1;
            end
          end
          PH_V_T1: begin
            if (c.up_t) phase_next = PH_V_T2;
            else fail = 1'b1;
          end
          PH_V_T2: begin
            if (c.up_t) phase_next = PH_V_P;
            else fail = 1'b1;
          end
          PH_V_P: begin
            if (c.up_p) phase_next = PH_V_SL;
            else fail = 1'b1;
          end
          PH_V_SL: begin
            if (c.slash) phase_next = PH_V_MAJ;
            else fail = 1'b1;
          end
          PH_V_MAJ: begin
            if (c.digit) begin
              held_major_next = item.low_nibble;
              phase_next      = PH_V_DOT;
            end else begin
              fail = 1'b1;
            end
          end
          PH_V_DOT: begin
            if (c.dot) phase_next = PH_V_MIN;
            else fail = 1'b1;
          end
          PH_V_MIN: begin
            if (c.digit) begin
              span_ok    = 1'b1;
              span_kind  = hrp_pkg::KIND_VERSION;
              span_len   = len + PW'(1);
              span_minor = item.low_nibble;
              phase_next = PH_CR;
            end else begin
              fail = 1'b1;
            end
          end
          PH_CR: begin
            if (c.cr) phase_next = PH_LF;
            else fail = 1'b1;
          end
          PH_LF: begin
            if (c.lf) phase_next = PH_F_FIRST;
            else fail = 1'b1;
          end
          PH_F_FIRST: begin
            if (c.cr) begin
              phase_next = PH_END_LF;
            end else if (c.tchar) begin
              span_start_next = pos;
              phase_next      = PH_F_NAME;
            end else begin
              fail = 1'b1;
            end
          end
          PH_F_NAME: begin
            if (c.tchar) begin
              phase_next = PH_F_NAME;
            end else if (c.colon) begin
              span_ok    = 1'b1;
              span_kind  = hrp_pkg::KIND_NAME;
              phase_next = PH_OWS;
            end else begin
              fail = 1'b1;
            end
          end
          PH_OWS: begin
            if (c.sp || c.tab) begin
              phase_next = PH_OWS;
            end else if (c.vchar) begin
              span_start_next = pos;
              phase_next      = PH_VALUE;
            end else if (c.cr) begin
              // empty value sits at the CR
              span_ok    = 1'b1;
              span_kind  = hrp_pkg::KIND_VALUE;
              span_off   = pos;
              span_len   = '0;
              phase_next = PH_LF;
            end else begin
              fail = 1'b1;
            end
          end
          PH_VALUE: begin
            if (c.vchar || c.sp || c.tab) begin
              phase_next = PH_VALUE;
            end else if (c.cr) begin
              span_ok    = 1'b1;
              span_kind  = hrp_pkg::KIND_VALUE;
              phase_next = PH_LF;
            end else begin
              fail = 1'b1;
            end
          end
          PH_END_LF: begin
            if (c.lf) begin
              span_ok    = 1'b1;
              span_kind  = hrp_pkg::KIND_DONE;
              span_off   = '0;
              span_len   = pos + PW'(1);
              phase_next = PH_DONE;
            end else begin
              fail = 1'b1;
            end
          end
          default: begin
            fail = 1'b1;
          end
        endcase
      end

      if (fail) begin
        phase_next = PH_FAILED;
      end
      // Fail, or end of message on an unfinished head
      err = fail ||
            (item.eom && phase_next != PH_DONE && phase_next != PH_FAILED);
    end

    // Drop all state at the end of the message
    if (item.eom) begin
      phase_next       = PH_M_FIRST;
      pos_next         = '0;
      span_start_next  = '0;
      hex_pending_next = '0;
      held_major_next  = '0;
    end
  end

  // Build result records; a span always goes before an error
  always_comb begin
    hrp_pkg::result_t span_rec;
    hrp_pkg::result_t err_rec;
    span_rec.kind   = span_kind;
    span_rec.offset = SW'(span_off);
    span_rec.length = SW'(span_len);
    span_rec.major  = (span_kind == hrp_pkg::KIND_VERSION) ? held_major : '0;
    span_rec.minor  = span_minor;
    span_rec.last   = !err;
    err_rec.kind    = hrp_pkg::KIND_ERROR;
    err_rec.offset  = SW'(pos);
    err_rec.length  = '0;
    err_rec.major   = '0;
    err_rec.minor   = '0;
    err_rec.last    = 1'b1;
    res0            = span_ok ? span_rec : err_rec;
    res1            = err_rec;
    res_push.first  = go && (span_ok || err);
    res_push.second = go && span_ok && err;
  end

  // Hold parser state, advance on each consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_M_FIRST;
      pos         <= '0;
      span_start  <= '0;
      hex_pending <= '0;
      held_major  <= '0;
    end else if (go) begin
      phase       <= phase_next;
      pos         <= pos_next;
      span_start  <= span_start_next;
      hex_pending <= hex_pending_next;
      held_major  <= held_major_next;
    end
  end

  // End of message always returns the parser to its start
  a_eom_restart: assert property (@(posedge clk) disable iff (rst)
    (go && item.eom) |=> (phase == PH_M_FIRST && pos == '0))
    else $error("parser not back at start after end of message");

  // A second result is always an error following a span
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    res_push.second |-> (res_push.first && res0.kind != hrp_pkg::KIND_ERROR &&
                         res1.kind == hrp_pkg::KIND_ERROR && !res0.last))
    else $error("bad ordering of a result pair");

endmodule

`default_nettype wire

>>> rtl/hrp_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser: result queue
// Takes up to two result records a cycle from the back end and presents the
// oldest one to the receiver.
// ----------------------------------------------------------------------------
module hrp_out_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire hrp_pkg::res_push_t  res_push,
  input  wire hrp_pkg::result_t    res0,
  input  wire hrp_pkg::result_t    res1,
  output logic                     room,
  output logic                     empty,
  input  wire logic                pop,
  output hrp_pkg::result_t         head
);

  localparam int DEPTH = hrp_pkg::OUT_Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  hrp_pkg::result_t mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;
  logic [AW:0]      n_wr;
  logic             rd;

  assign n_wr  = (AW + 1)'(res_push.first) + (AW + 1)'(res_push.second);
  assign rd    = pop && !empty;
  assign empty = (count == '0);
  assign room  = (count <= (AW + 1)'(DEPTH - 2));
  assign head  = mem[rptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(n_wr);
      if (rd) begin
        rptr <= rptr + AW'(1);
      end
      count <= count + n_wr - (AW + 1)'(rd);
    end
  end

  // Store one or two records
  always_ff @(posedge clk) begin
    if (res_push.first) begin
      mem[wptr] <= res0;
    end
    if (res_push.second) begin
      mem[wptr + AW'(1)] <= res1;
    end
  end

  // Fill level never passes the depth
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW + 1)'(DEPTH))
    else $error("result queue overflow");

  // Writes only arrive in a cycle that reports room
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    (res_push.first && !room) |-> 1'b0)
    else $error("result written without room");

endmodule

`default_nettype wire

>>> tb/hrp_span_checker.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: span checker
// Watches the byte and result queues of the parser. Each accepted byte is run
// through an independent model of the request-head grammar, and the spans it
// owes are held in order. Each popped result is compared field by field with
// the oldest owed span. Reports a running mismatch count and the number of
// spans still owed to the top level.
// ----------------------------------------------------------------------------
module hrp_span_checker #(
  parameter int POSITION_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      end_of_message,
  input  wire logic                      push,
  input  wire logic                      full,
  input  wire logic [hrp_pkg::KIND_W-1:0] span_kind,
  input  wire logic [hrp_pkg::SPAN_W-1:0] span_offset,
  input  wire logic [hrp_pkg::SPAN_W-1:0] span_length,
  input  wire logic [hrp_pkg::VER_W-1:0]  major_version,
  input  wire logic [hrp_pkg::VER_W-1:0]  minor_version,
  input  wire logic                      run_last,
  input  wire logic                      empty,
  input  wire logic                      pop,
  output int                             mismatch_count,
  output int                             spans_owed,
  output int                             spans_seen,
  output int                             heads_done,
  output int                             errors_seen
);

  localparam int         SW       = hrp_pkg::SPAN_W;
  localparam int         PW       = POSITION_WIDTH;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_GRAVE = 8'h60;

  typedef enum logic [4:0] {
    ST_METHOD_FIRST, ST_METHOD, ST_SLASH, ST_PATH, ST_PATH_ESC, ST_QUERY,
    ST_QUERY_ESC, ST_VER_H, ST_VER_T1, ST_VER_T2, ST_VER_P, ST_VER_SLASH,
    ST_VER_MAJOR, ST_VER_DOT, ST_VER_MINOR, ST_LINE_CR, ST_LINE_LF,
    ST_FIELD_FIRST, ST_FIELD_NAME, ST_FIELD_OWS, ST_FIELD_VALUE, ST_HEAD_LF,
    ST_HEAD_DONE, ST_HEAD_FAILED
  } head_state_t;

  head_state_t               phase;
  logic [PW-1:0]             byte_pos;
  logic [PW-1:0]             span_from;
  logic [1:0]                esc_left;
  logic [hrp_pkg::VER_W-1:0] held_major;
  hrp_pkg::result_t          pending_spans[$];

  // Character classes of the request-head grammar
  function automatic logic dec_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return dec_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic visible_char(input logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h7E) || c >= 8'h80;
  endfunction

  function automatic logic tok_char(input logic [7:0] c);
    case (c)
      "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", CH_GRAVE,
      "|", "~": return 1'b1;
      default: return letter(c) || dec_digit(c);
    endcase
  endfunction

  // Path character, leaving out the percent escape
  function automatic logic path_char(input logic [7:0] c);
    case (c)
      "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";",
      "=", ":", "@": return 1'b1;
      default: return letter(c) || dec_digit(c);
    endcase
  endfunction

  function automatic hrp_pkg::result_t span_rec(
    input logic [hrp_pkg::KIND_W-1:0] kind,
    input logic [PW-1:0]              off,
    input logic [PW-1:0]              len,
    input logic [hrp_pkg::VER_W-1:0]  maj,
    input logic [hrp_pkg::VER_W-1:0]  mnr
  );
    hrp_pkg::result_t r;
    r.kind   = kind;
    r.offset = SW'(off);
    r.length = SW'(len);
    r.major  = maj;
    r.minor  = mnr;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic void restart_head();
    phase      = ST_METHOD_FIRST;
    byte_pos   = '0;
    span_from  = '0;
    esc_left   = '0;
    held_major = '0;
  endfunction

  // Advance the grammar by one byte and queue the spans it completes
  function automatic void advance_grammar(input logic [7:0] c, input logic eom);
    hrp_pkg::result_t made[$];
    logic [PW-1:0]    here;
    logic [PW-1:0]    run;
    logic             bad;
    here = byte_pos;
    run  = here - span_from;
    bad  = 1'b0;
    if (phase == ST_HEAD_DONE || phase == ST_HEAD_FAILED) begin
      // Drop bytes until the end of the buffer
      if (eom) restart_head();
    end else begin
      if (here == {PW{1'b1}}) begin
        bad = 1'b1;
      end else begin
        byte_pos = here + PW'(1);
        case (phase)
          ST_METHOD_FIRST: begin
            if (tok_char(c)) begin
              span_from = here;
              phase     = ST_METHOD;
            end else bad = 1'b1;
          end
          ST_METHOD: begin
            if (tok_char(c)) begin
            end else if (c == " ") begin
              made.push_back(span_rec(hrp_pkg::KIND_METHOD, span_from, run, '0, '0));
              phase = ST_SLASH;
            end else bad = 1'b1;
          end
          ST_SLASH: begin
            if (c == "/") begin
              span_from = here;
              phase     = ST_PATH;
            end else bad = 1'b1;
          end
          ST_PATH, ST_QUERY: begin
            if (path_char(c) || c == "/" || (c == "?" && phase == ST_QUERY)) begin
            end else if (c == "%") begin
              esc_left = 2'd2;
              if (phase == ST_PATH) phase = ST_PATH_ESC;
              else phase = ST_QUERY_ESC;
            end else if (c == "?") begin
              made.push_back(span_rec(hrp_pkg::KIND_PATH, span_from, run, '0, '0));
              span_from = here;
              phase     = ST_QUERY;
            end else if (c == " ") begin
              if (phase == ST_PATH)
                made.push_back(span_rec(hrp_pkg::KIND_PATH, span_from, run, '0, '0));
              else
                made.push_back(span_rec(hrp_pkg::KIND_QUERY, span_from, run, '0, '0));
              phase = ST_VER_H;
            end else bad = 1'b1;
          end
          ST_PATH_ESC, ST_QUERY_ESC: begin
            if (!hex_digit(c)) begin
              bad = 1'b1;
            end else begin
              esc_left = esc_left - 2'd1;
              if (esc_left == 2'd0) begin
                if (phase == ST_PATH_ESC) phase = ST_PATH;
                else phase = ST_QUERY;
              end
            end
          end
          ST_VER_H: begin
            if (c == "H") begin
              span_from = here;
              phase     = ST_VER_T1;
            end else bad = 1'b1;
          end
          ST_VER_T1: if (c == "T") phase = ST_VER_T2; else bad = 1'b1;
          ST_VER_T2: if (c == "T") phase = ST_VER_P; else bad = 1'b1;
          ST_VER_P: if (c == "P") phase = ST_VER_SLASH; else bad = 1'b1;
          ST_VER_SLASH: if (c == "/") phase = ST_VER_MAJOR; else bad = 1'b1;
          ST_VER_MAJOR: begin
            if (dec_digit(c)) begin
              held_major = c[3:0];
              phase      = ST_VER_DOT;
            end else bad = 1'b1;
          end
          ST_VER_DOT: if (c == ".") phase = ST_VER_MINOR; else bad = 1'b1;
          ST_VER_MINOR: begin
            if (dec_digit(c)) begin
              made.push_back(span_rec(hrp_pkg::KIND_VERSION, span_from,
                                      run + PW'(1), held_major, c[3:0]));
              phase = ST_LINE_CR;
            end else bad = 1'b1;
          end
          ST_LINE_CR: if (c == CH_CR) phase = ST_LINE_LF; else bad = 1'b1;
          ST_LINE_LF: if (c == CH_LF) phase = ST_FIELD_FIRST; else bad = 1'b1;
          ST_FIELD_FIRST: begin
            if (c == CH_CR) begin
              phase = ST_HEAD_LF;
            end else if (tok_char(c)) begin
              span_from = here;
              phase     = ST_FIELD_NAME;
            end else bad = 1'b1;
          end
          ST_FIELD_NAME: begin
            if (tok_char(c)) begin
            end else if (c == ":") begin
              made.push_back(span_rec(hrp_pkg::KIND_NAME, span_from, run, '0, '0));
              phase = ST_FIELD_OWS;
            end else bad = 1'b1;
          end
          ST_FIELD_OWS: begin
            if (c == " " || c == CH_TAB) begin
            end else if (visible_char(c)) begin
              span_from = here;
              phase     = ST_FIELD_VALUE;
            end else if (c == CH_CR) begin
              // Blank value: zero length at the CR
              made.push_back(span_rec(hrp_pkg::KIND_VALUE, here, '0, '0, '0));
              phase = ST_LINE_LF;
            end else bad = 1'b1;
          end
          ST_FIELD_VALUE: begin
            if (visible_char(c) || c == " " || c == CH_TAB) begin
            end else if (c == CH_CR) begin
              made.push_back(span_rec(hrp_pkg::KIND_VALUE, span_from, run, '0, '0));
              phase = ST_LINE_LF;
            end else bad = 1'b1;
          end
          ST_HEAD_LF: begin
            if (c == CH_LF) begin
              made.push_back(span_rec(hrp_pkg::KIND_DONE, '0, here + PW'(1), '0, '0));
              phase = ST_HEAD_DONE;
            end else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      if (bad) begin
        made.push_back(span_rec(hrp_pkg::KIND_ERROR, here, '0, '0, '0));
        phase = ST_HEAD_FAILED;
      end
      // An unfinished head at the end of the buffer is an error
      if (eom) begin
        if (phase != ST_HEAD_DONE && phase != ST_HEAD_FAILED)
          made.push_back(span_rec(hrp_pkg::KIND_ERROR, here, '0, '0, '0));
        restart_head();
      end
      if (made.size() > 0) made[made.size()-1].last = 1'b1;
      foreach (made[i]) pending_spans.push_back(made[i]);
    end
  endfunction

  function automatic void note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR: %s", what);
  endfunction

  // Compare one popped result with the oldest owed span
  function automatic void check_span();
    hrp_pkg::result_t want;
    hrp_pkg::result_t got;
    got.kind   = span_kind;
    got.offset = span_offset;
    got.length = span_length;
    got.major  = major_version;
    got.minor  = minor_version;
    got.last   = run_last;
    spans_seen++;
    if (span_kind == hrp_pkg::KIND_DONE) heads_done++;
    if (span_kind == hrp_pkg::KIND_ERROR) errors_seen++;
    if (pending_spans.size() == 0) begin
      note_failure($sformatf("result with nothing owed: kind %0d off %0d len %0d",
                             got.kind, got.offset, got.length));
    end else begin
      want = pending_spans.pop_front();
      if (got.kind !== want.kind || got.offset !== want.offset ||
          got.length !== want.length || got.major !== want.major ||
          got.minor !== want.minor || got.last !== want.last)
        note_failure($sformatf({"span %0d: expected kind %0d off %0d len %0d ",
                                "ver %0d.%0d last %0d, got kind %0d off %0d ",
                                "len %0d ver %0d.%0d last %0d"},
                               spans_seen, want.kind, want.offset, want.length,
                               want.major, want.minor, want.last, got.kind,
                               got.offset, got.length, got.major, got.minor,
                               got.last));
    end
  endfunction

  // Sample both queues at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      restart_head();
      pending_spans.delete();
      mismatch_count = 0;
      spans_seen     = 0;
      heads_done     = 0;
      errors_seen    = 0;
    end else begin
      if (pop && !empty) check_span();
      if (push && !full) advance_grammar(data_byte, end_of_message);
    end
    spans_owed = pending_spans.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// HTTP request head parser: testbench top
// Feeds request heads byte by byte: a few directed heads, then random
// well-formed, damaged and junk messages, with random gaps on the byte side
// and random stalls on the result side. The span checker predicts and
// compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int    POS_W      = 16;
  localparam int    RAND_BYTES = 700;
  localparam string CRLF       = "\015\012";
  localparam string TOKEN_SET  =
    "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  localparam string PCHAR_SET  =
    "-._~!$&'()*+,;=:@0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  localparam string HEX_SET    = "0123456789ABCDEFabcdef";

  logic        clk;
  logic        rst;
  logic [7:0]  data_byte;
  logic        end_of_message;
  logic        push;
  logic        full;
  logic [2:0]  span_kind;
  logic [15:0] span_offset;
  logic [15:0] span_length;
  logic [3:0]  major_version;
  logic [3:0]  minor_version;
  logic        run_last;
  logic        empty;
  logic        pop;

  int          mismatch_count;
  int          spans_owed;
  int          spans_seen;
  int          heads_done;
  int          errors_seen;
  int          bytes_sent;
  int          messages_sent;
  bit          calm;
  logic [8:0]  msg[$];   // {end_of_message, data_byte}

  http_request_head_parser_core #(
    .POSITION_WIDTH(POS_W)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .push          (push),
    .full          (full),
    .span_kind     (span_kind),
    .span_offset   (span_offset),
    .span_length   (span_length),
    .major_version (major_version),
    .minor_version (minor_version),
    .run_last      (run_last),
    .empty         (empty),
    .pop           (pop)
  );

  hrp_span_checker #(
    .POSITION_WIDTH(POS_W)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .end_of_message(end_of_message),
    .push          (push),
    .full          (full),
    .span_kind     (span_kind),
    .span_offset   (span_offset),
    .span_length   (span_length),
    .major_version (major_version),
    .minor_version (minor_version),
    .run_last      (run_last),
    .empty         (empty),
    .pop           (pop),
    .mismatch_count(mismatch_count),
    .spans_owed    (spans_owed),
    .spans_seen    (spans_seen),
    .heads_done    (heads_done),
    .errors_seen   (errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #10_000_000;
    $display("http_request_head_parser_core test failed");
    $finish;
  end

  // Result side: pop in random runs with stall bursts, steady once calm
  initial begin
    pop = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  // Message building
  function automatic logic [7:0] pick(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] tok_pick();
    if ($urandom_range(0, 39) == 0) return 8'h60;
    return pick(TOKEN_SET);
  endfunction

  function automatic logic [7:0] value_pick();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    msg.push_back({1'b0, b});
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void mark_end();
    msg[msg.size()-1][8] = 1'b1;
  endfunction

  function automatic void add_target(input bit in_query);
    int r;
    repeat ($urandom_range(0, 6)) begin
      r = $urandom_range(0, 9);
      if (r == 6) begin
        add_byte("/");
      end else if (r == 7) begin
        add_byte("%");
        add_byte(pick(HEX_SET));
        add_byte(pick(HEX_SET));
      end else if (r == 8 && in_query) begin
        add_byte("?");
      end else begin
        add_byte(pick(PCHAR_SET));
      end
    end
  endfunction

  function automatic void build_request();
    repeat ($urandom_range(1, 5)) add_byte(tok_pick());
    add_text(" /");
    add_target(1'b0);
    if ($urandom_range(0, 1) == 1) begin
      add_byte("?");
      add_target(1'b1);
    end
    add_text(" HTTP/");
    add_byte(8'("0" + $urandom_range(0, 9)));
    add_byte(".");
    add_byte(8'("0" + $urandom_range(0, 9)));
    add_text(CRLF);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 6)) add_byte(tok_pick());
      add_byte(":");
      repeat ($urandom_range(0, 2)) add_byte(pick(" \t"));
      // Mostly a value, sometimes left blank; trailing blanks stay in it
      if ($urandom_range(0, 3) != 0) begin
        add_byte(value_pick());
        repeat ($urandom_range(0, 6))
          add_byte(($urandom_range(0, 3) == 0) ? pick(" \t") : value_pick());
      end
      add_text(CRLF);
    end
    add_text(CRLF);
  endfunction

  // Hold the byte side idle for a number of cycles
  task automatic hold_off(input int cycles);
    push <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Send the built message, one byte per handshake; call at a falling edge
  task automatic send_message(input int counted);
    foreach (msg[i]) begin
      if (!calm && $urandom_range(0, 9) == 0) hold_off($urandom_range(1, 16));
      data_byte      <= msg[i][7:0];
      end_of_message <= msg[i][8];
      push           <= 1'b1;
      do @(posedge clk); while (full);
      @(negedge clk);
    end
    bytes_sent += counted;
    messages_sent++;
    msg.delete();
  endtask

  task automatic drain_spans();
    push <= 1'b0;
    while (spans_owed != 0) @(negedge clk);
  endtask

  initial begin
    int counted;
    int kind;
    int cut;
    bit damaged;
    rst            = 1'b1;
    push           = 1'b0;
    data_byte      = 8'h00;
    end_of_message = 1'b0;
    calm           = 1'b0;
    bytes_sent     = 0;
    messages_sent  = 0;
    counted        = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extreme versions, escapes in both cases, query with '?',
    // blank value, done, early end, bad byte, bad escape, bytes after error
    add_text({"~ /%aF/b?%0A?/ HTTP/9.0", CRLF, "x:", CRLF, CRLF});
    mark_end();
    send_message(msg.size());
    add_text("G");
    mark_end();
    send_message(msg.size());
    add_text("GET ");
    mark_end();
    send_message(msg.size());
    add_byte(8'h00);
    add_byte(8'hFF);
    mark_end();
    send_message(msg.size());
    add_text("A /%G");
    mark_end();
    send_message(msg.size());

    // Let every owed span come out before going on
    drain_spans();

    // Random: mostly well-formed heads, mixed with damaged heads and junk
    while (counted < RAND_BYTES) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        build_request();
        cut = msg.size();
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
      end else if (kind < 17) begin
        build_request();
        damaged = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          msg[$urandom_range(0, msg.size() - 1)][7:0] = 8'($urandom);
          damaged = 1'b1;
        end
        if (!damaged || $urandom_range(0, 1) == 1) begin
          cut = $urandom_range(1, msg.size());
          while (msg.size() > cut) void'(msg.pop_back());
        end
        cut = msg.size();
      end else begin
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
        cut = msg.size();
      end
      mark_end();
      send_message(cut);
      counted += cut;
      if (counted >= RAND_BYTES - 100) calm = 1'b1;
    end

    drain_spans();
    repeat (20) @(negedge clk);

    $display("Sent %0d bytes in %0d directed and random messages under stalls.",
             bytes_sent, messages_sent);
    $display("Checked %0d spans: %0d finished heads and %0d errors.",
             spans_seen, heads_done, errors_seen);
    if (mismatch_count == 0) begin
      $display("http_request_head_parser_core test passed");
    end else begin
      $display("http_request_head_parser_core test failed");
    end
    $finish;
  end

endmodule
